### design/msca_pkg.sv
`timescale 1ns / 1ps

package msca_pkg;

  // Pool size and the widths that follow from it
  localparam int NUM_CELLS = 256;
  localparam int IDX_W     = $clog2(NUM_CELLS);
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);

  // Port field widths
  localparam int ACT_W   = 2;
  localparam int CELL_W  = 8;
  localparam int LIVE_W  = 9;
  localparam int TOTAL_W = 32;

  localparam logic [LIVE_W-1:0] ALIVE_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_SWEEP = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] next;
  } link_entry_t;

  typedef struct packed {
    logic             mark_we;
    logic             mark_wbit;
    logic [IDX_W-1:0] mark_waddr;
    logic [IDX_W-1:0] mark_raddr;
    logic             link_we;
    logic [IDX_W-1:0] link_waddr;
    link_entry_t      link_wdata;
    logic [IDX_W-1:0] link_raddr;
  } store_req_t;

endpackage

### design/mark_sweep_cell_allocator_core.sv
`timescale 1ns / 1ps

// Mark-sweep cell allocator over a pool of 256 cells.
// Request channel: in_action, in_cell_index and in_sweep_start are taken at a
// rising edge with start high and busy low. busy stays high while a request
// is in progress. Result channel: out_valid is high for exactly one cycle
// with out_ok, out_granted_cell, out_was_marked, out_live_count and
// out_alloc_total; the receiver cannot stall, so every result is taken then.
// Allocate and mark go via ST_ALLOC or ST_MARK on a registered read of the
// cell store (mark writes back after it, allocate at accept). Empty-list
// allocate, no-op and a sweep starting past the pool answer from idle. Each
// swept cell costs a registered read and a write-back (mark clear or free-list
// push) via one shared incrementer. A new request may be accepted in the
// cycle its predecessor's result shows. Reset clears all marks and counters
// and leaves the free list empty; sweep once after reset to build it.
module mark_sweep_cell_allocator_core
  import msca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [CELL_W-1:0]  in_cell_index,
  input  logic [CELL_W-1:0]  in_sweep_start,
  output logic               out_valid,
  output logic               out_ok,
  output logic [CELL_W-1:0]  out_granted_cell,
  output logic               out_was_marked,
  output logic [LIVE_W-1:0]  out_live_count,
  output logic [TOTAL_W-1:0] out_alloc_total
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_MARK,
    ST_SW_RD,
    ST_SW_WR
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    free_head_r, free_head_nxt;
  logic                free_ne_r, free_ne_nxt;
  logic [LIVE_W-1:0]   alive_r, alive_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    cell_r, cell_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [CELL_W-1:0]   out_granted_r, out_granted_nxt;
  logic                out_was_r, out_was_nxt;
  logic [LIVE_W-1:0]   out_live_r, out_live_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  store_req_t          req;
  logic                mark_rd;
  link_entry_t         link_rd;

  // Shared incrementer: sweep index in ST_SW_RD, live count elsewhere
  logic [LIVE_W-1:0]   inc_in, inc_out;
  logic [LIVE_W-1:0]   alive_inc;
  action_t             act;

  assign act       = action_t'(in_action);
  assign inc_in    = (state_r == ST_SW_RD) ? LIVE_W'(idx_r) : alive_r;
  assign inc_out   = inc_in + LIVE_W'(1);
  assign alive_inc = (alive_r == ALIVE_MAX) ? alive_r : inc_out;

  msca_cell_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .mark_rd (mark_rd),
    .link_rd (link_rd)
  );

  always_comb begin
    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    free_ne_nxt     = free_ne_r;
    alive_nxt       = alive_r;
    total_nxt       = total_r;
    idx_nxt         = idx_r;
    cell_nxt        = cell_r;
    out_valid_nxt   = 1'b0;
    out_ok_nxt      = 1'b0;
    out_granted_nxt = '0;
    out_was_nxt     = 1'b0;
    out_live_nxt    = alive_r;
    out_total_nxt   = total_r;

    req            = '0;
    req.link_raddr = free_head_r;
    req.mark_raddr = in_cell_index[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (act)
            ACT_ALLOC: begin
              if (free_ne_r) begin
                // clear the head cell's mark and fetch its successor
                req.mark_we    = 1'b1;
                req.mark_wbit  = 1'b0;
                req.mark_waddr = free_head_r;
                state_nxt      = ST_ALLOC;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_MARK: begin
              if (32'(in_cell_index) < NUM_CELLS) begin
                cell_nxt  = in_cell_index[IDX_W-1:0];
                state_nxt = ST_MARK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_SWEEP: begin
              alive_nxt     = '0;
              free_head_nxt = '0;
              free_ne_nxt   = 1'b0;
              if (32'(in_sweep_start) < NUM_CELLS) begin
                idx_nxt   = CNT_W'(in_sweep_start);
                state_nxt = ST_SW_RD;
              end else begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b1;
                out_live_nxt  = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        free_ne_nxt     = link_rd.valid;
        free_head_nxt   = link_rd.valid ? link_rd.next : '0;
        total_nxt       = total_r + TOTAL_W'(1);
        alive_nxt       = alive_inc;
        out_valid_nxt   = 1'b1;
        out_ok_nxt      = 1'b1;
        out_granted_nxt = CELL_W'(free_head_r);
        out_live_nxt    = alive_inc;
        out_total_nxt   = total_r + TOTAL_W'(1);
        state_nxt       = ST_IDLE;
      end

      ST_MARK: begin
        req.mark_we    = 1'b1;
        req.mark_wbit  = 1'b1;
        req.mark_waddr = cell_r;
        out_valid_nxt  = 1'b1;
        out_ok_nxt     = 1'b1;
        out_was_nxt    = mark_rd;
        state_nxt      = ST_IDLE;
      end

      ST_SW_RD: begin
        req.mark_raddr = idx_r[IDX_W-1:0];
        cell_nxt       = idx_r[IDX_W-1:0];
        idx_nxt        = CNT_W'(inc_out);
        state_nxt      = ST_SW_WR;
      end

      ST_SW_WR: begin
        if (mark_rd) begin
          req.mark_we    = 1'b1;
          req.mark_wbit  = 1'b0;
          req.mark_waddr = cell_r;
          alive_nxt      = alive_inc;
        end else begin
          // push onto the rebuilt free list
          req.link_we          = 1'b1;
          req.link_waddr       = cell_r;
          req.link_wdata.valid = free_ne_r;
          req.link_wdata.next  = free_head_r;
          free_head_nxt        = cell_r;
          free_ne_nxt          = 1'b1;
        end
        if (32'(idx_r) == NUM_CELLS) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_live_nxt  = alive_nxt;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SW_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= '0;
      free_ne_r   <= 1'b0;
      alive_r     <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      free_ne_r   <= free_ne_nxt;
      alive_r     <= alive_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r        <= cell_nxt;
    out_ok_r      <= out_ok_nxt;
    out_granted_r <= out_granted_nxt;
    out_was_r     <= out_was_nxt;
    out_live_r    <= out_live_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_granted_cell = out_granted_r;
  assign out_was_marked   = out_was_r;
  assign out_live_count   = out_live_r;
  assign out_alloc_total  = out_total_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_sweep_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SW_WR) |=> (state_r == ST_SW_RD || state_r == ST_IDLE))
    else $error("sweep write-back not followed by next read or finish");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC) |=>
      (out_valid && out_ok && out_alloc_total == $past(total_r) + TOTAL_W'(1)))
    else $error("granted allocation did not advance the allocation count");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !busy)
    else $error("busy raised without a request");

endmodule

### design/msca_cell_store.sv
`timescale 1ns / 1ps

module msca_cell_store
  import msca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  store_req_t  req,
  output logic        mark_rd,
  output link_entry_t link_rd
);

  logic        mark_mem [NUM_CELLS];
  link_entry_t link_mem [NUM_CELLS];
  logic [NUM_CELLS-1:0] mark_vld_r;

  // An entry never written since reset reads as unmarked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_vld_r <= '0;
    end else if (req.mark_we) begin
      mark_vld_r[req.mark_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.mark_we) begin
      mark_mem[req.mark_waddr] <= req.mark_wbit;
    end
    mark_rd <= mark_vld_r[req.mark_raddr] & mark_mem[req.mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    link_rd <= link_mem[req.link_raddr];
  end

endmodule
